### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is low.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed: %m");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    `ASSERT_PROP(lbl, clk, rstn, (ante) |=> (cons))

`endif

### sv/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg
// Types, constants and control bundles of the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int IN_W  = 24;  // opcode, character, column, row
    localparam int OUT_W = 32;  // cursor_row, cursor_column, read char/attr, scrolled

    localparam logic [7:0] TEXT_COLOR_INIT = 8'h07;
    localparam logic [7:0] CH_SPACE        = 8'h20;
    localparam logic [7:0] CH_NEWLINE      = 8'h0a;
    localparam logic [7:0] CH_RETURN       = 8'h0d;

    typedef enum logic [2:0] {
        OP_PUT    = 3'd0,
        OP_BKSP   = 3'd1,
        OP_INVERT = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;   // latch the incoming word
        logic exec;     // single-step action of the latched opcode
        logic scroll;   // one step of the row move
        logic blank;    // one step of bottom row blanking
        logic clear;    // one step of the screen clear
        logic cnt_clr;  // restart the sweep counter
        logic load;     // load the result register
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       pending;     // cursor sits past the last row
        logic       move_last;
        logic       blank_last;
        logic       clear_last;
        logic       out_free;    // result register can take a word
    } dp_status_t;

endpackage

### sv/tmcw_ram.sv
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/tmcw_ctrl.sv
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Sequencer: accepts a word, runs the single step or the scroll/clear sweeps,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module tmcw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tmcw_pkg::dp_status_t status,
    output tmcw_pkg::dp_cmd_t    cmd
);

    import tmcw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.op == OP_PUT && status.pending) begin
                    state_next = ST_SCROLL;
                end else if (status.op == OP_CLEAR) begin
                    state_next = ST_CLEAR;
                end else begin
                    state_next = status.out_free ? ST_IDLE : ST_RESULT;
                end
            end
            ST_SCROLL: begin
                if (status.move_last) begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (status.blank_last) begin
                    state_next = ST_EXEC;
                end
            end
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = status.out_free ? ST_IDLE : ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_EXEC: begin
                if (status.op == OP_PUT && status.pending) begin
                    cmd.cnt_clr = 1'b1;
                end else if (status.op == OP_CLEAR) begin
                    cmd.exec    = 1'b1;
                    cmd.cnt_clr = 1'b1;
                end else begin
                    cmd.exec = 1'b1;
                    cmd.load = status.out_free;
                end
            end
            ST_SCROLL: begin
                cmd.scroll  = 1'b1;
                cmd.cnt_clr = status.move_last;
            end
            ST_BLANK: begin
                cmd.blank = 1'b1;
            end
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                cmd.load  = status.clear_last && status.out_free;
            end
            ST_RESULT: begin
                cmd.load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### sv/tmcw_dp.sv
// ----------------------------------------------------------------------------
// tmcw_dp
// Datapath: cursor, color, latched word, sweep counter, cell RAM ports and
// the result register.
// ----------------------------------------------------------------------------
module tmcw_dp #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [7:0]                  cfg_wdata,
    input  logic [tmcw_pkg::IN_W-1:0]   s_tdata,
    input  tmcw_pkg::dp_cmd_t           cmd,
    output tmcw_pkg::dp_status_t        status,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tmcw_pkg::OUT_W-1:0]  m_tdata
);

    import tmcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int MOVE   = CELLS - COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int OFF_W  = $clog2(CELLS + COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS);

    // input word fields
    logic [2:0] in_op;
    logic [7:0] in_ch;
    logic [6:0] in_col;
    logic [4:0] in_row;
    logic       in_range;
    logic [ADDR_W-1:0] in_addr;

    assign in_op  = s_tdata[2:0];
    assign in_ch  = s_tdata[10:3];
    assign in_col = s_tdata[17:11];
    assign in_row = s_tdata[22:18];
    assign in_range = (32'(in_col) < 32'(COLUMNS)) && (32'(in_row) < 32'(ROWS));
    assign in_addr  = in_range
        ? ADDR_W'(ADDR_W'(in_row) * ADDR_W'(COLUMNS) + ADDR_W'(in_col)) : '0;

    logic [2:0]        op_reg,     op_next;
    logic [7:0]        ch_reg,     ch_next;
    logic              range_reg,  range_next;
    logic [ADDR_W-1:0] addr_reg,   addr_next;
    logic [7:0]        color_reg,  color_next;
    logic [ROW_W-1:0]  row_reg,    row_next;
    logic [COL_W-1:0]  col_reg,    col_next;
    logic [OFF_W-1:0]  off_reg,    off_next;
    logic [ADDR_W-1:0] cnt_reg,    cnt_next;
    logic [7:0]        rch_reg,    rch_next;
    logic [7:0]        rattr_reg,  rattr_next;
    logic              scr_reg,    scr_next;
    logic              mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]  mdata_reg,  mdata_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;
    logic              move_last;
    logic              blank_last;
    logic              out_free;

    assign move_last  = (cnt_reg == ADDR_W'(MOVE));
    assign blank_last = (cnt_reg == ADDR_W'(COLUMNS - 1));
    assign out_free   = !mvalid_reg || m_tready;

    tmcw_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        op_next     = op_reg;
        ch_next     = ch_reg;
        range_next  = range_reg;
        addr_next   = addr_reg;
        color_next  = color_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        off_next    = off_reg;
        cnt_next    = cnt_reg;
        rch_next    = rch_reg;
        rattr_next  = rattr_reg;
        scr_next    = scr_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b1;
        ram_raddr   = in_addr;   // the addressed cell is read while a word is taken

        if (cmd.accept) begin
            op_next    = in_op;
            ch_next    = in_ch;
            range_next = in_range;
            addr_next  = in_addr;
            rch_next   = '0;
            rattr_next = '0;
            scr_next   = 1'b0;
        end

        // row move: read runs one row ahead, write uses the registered read data
        if (cmd.scroll) begin
            ram_raddr = ADDR_W'(32'(cnt_reg) + COLUMNS);
            ram_re    = !move_last;
            if (cnt_reg != '0) begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg - ADDR_W'(1);
                ram_wdata = ram_rdata;
            end
        end

        if (cmd.blank) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(MOVE) + cnt_reg;
            ram_wdata = {color_reg, CH_SPACE};
            if (blank_last) begin
                row_next = ROW_W'(ROWS - 1);
                off_next = off_reg - OFF_W'(COLUMNS);
                scr_next = 1'b1;
            end
        end

        if (cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
            ram_wdata = {TEXT_COLOR_INIT, CH_SPACE};
        end

        if (cmd.exec) begin
            case (op_reg)
                OP_PUT: begin
                    if (ch_reg == CH_NEWLINE) begin
                        row_next = row_reg + ROW_W'(1);
                        off_next = off_reg + OFF_W'(COLUMNS);
                    end else if (ch_reg == CH_RETURN) begin
                        col_next = '0;
                        off_next = off_reg - OFF_W'(col_reg);
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = off_reg[ADDR_W-1:0];
                        ram_wdata = {color_reg, ch_reg};
                        off_next  = off_reg + OFF_W'(1);
                        if (col_reg == COL_W'(COLUMNS - 1)) begin
                            col_next = '0;
                            row_next = row_reg + ROW_W'(1);
                        end else begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                end
                OP_BKSP: begin
                    if (off_reg != '0) begin
                        off_next = off_reg - OFF_W'(1);
                        // inside the grid unless the cursor was past column 0 of the pending row
                        if (off_next < OFF_W'(CELLS)) begin
                            ram_we    = 1'b1;
                            ram_waddr = off_next[ADDR_W-1:0];
                            ram_wdata = {color_reg, CH_SPACE};
                        end
                        if (col_reg == '0) begin
                            col_next = COL_W'(COLUMNS - 1);
                            row_next = row_reg - ROW_W'(1);
                        end else begin
                            col_next = col_reg - COL_W'(1);
                        end
                    end
                end
                OP_INVERT: begin
                    if (range_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = addr_reg;
                        ram_wdata = {ram_rdata[11:8], ram_rdata[15:12], ram_rdata[7:0]};
                    end
                end
                OP_READ: begin
                    if (range_reg) begin
                        rch_next   = ram_rdata[7:0];
                        rattr_next = ram_rdata[15:8];
                    end
                end
                OP_CLEAR: begin
                    color_next = TEXT_COLOR_INIT;
                    row_next   = '0;
                    col_next   = '0;
                    off_next   = '0;
                end
                default: begin
                end
            endcase
        end

        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.scroll || cmd.blank || cmd.clear) begin
            cnt_next = cnt_reg + ADDR_W'(1);
        end

        if (cfg_we) begin
            color_next = cfg_wdata;
        end

        if (cmd.load) begin
            mvalid_next = 1'b1;
            mdata_next  = {3'b000, scr_next, rattr_next, rch_next,
                           7'(col_next), 5'(row_next)};
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg  <= TEXT_COLOR_INIT;
            row_reg    <= '0;
            col_reg    <= '0;
            off_reg    <= '0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            color_reg  <= color_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            off_reg    <= off_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        ch_reg    <= ch_next;
        range_reg <= range_next;
        addr_reg  <= addr_next;
        rch_reg   <= rch_next;
        rattr_reg <= rattr_next;
        scr_reg   <= scr_next;
        mdata_reg <= mdata_next;
    end

    assign status.op         = op_reg;
    assign status.pending    = (row_reg == ROW_W'(ROWS));
    assign status.move_last  = move_last;
    assign status.blank_last = blank_last;
    assign status.clear_last = (cnt_reg == ADDR_W'(CELLS - 1));
    assign status.out_free   = out_free;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

### sv/text_mode_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit
// Text-mode console: cell RAM plus cursor, driven by one command per word.
//
//   channel   dir  handshake          payload
//   s_        in   s_tvalid/s_tready  s_tdata: opcode, character, column, row
//   m_        out  m_tvalid/m_tready  m_tdata: cursor, read cell, scrolled
//   cfg_      in   cfg_we             cfg_wdata: text color
//
// An ordinary word passes through accept (the addressed cell is read) and
// one read-modify-write of the single-write-port cell RAM.
// A put with a pending scroll adds a row move and a bottom row blank before
// the put itself; clear writes every cell, one cell per cycle.
// Reset clears cursor, color, counter and valid; cell RAM has no reset value.
// One result register: the next word is taken while a result waits, and a
// finished word holds until that register is free.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [7:0]                  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [2:0] opcode, [10:3] character, [17:11] column, [22:18] row
    input  logic [tmcw_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [4:0] cursor_row, [11:5] cursor_column, [19:12] read_character,
    // [27:20] read_attribute, [28] scrolled
    output logic [tmcw_pkg::OUT_W-1:0]  m_tdata
);

    import tmcw_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tmcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tmcw_dp #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### sv/tmcw_checker.sv
// ----------------------------------------------------------------------------
// tmcw_checker
// Port-level checks of the console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmcw_checker #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [tmcw_pkg::IN_W-1:0]   s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [tmcw_pkg::OUT_W-1:0]  m_tdata
);

    localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);
    localparam logic [4:0] ROW_PEND = 5'(ROWS);

    logic [4:0] out_row;
    logic [6:0] out_col;
    logic       out_scr;
    logic       in_word;

    assign out_row = m_tdata[4:0];
    assign out_col = m_tdata[11:5];
    assign out_scr = m_tdata[28];
    assign in_word = s_tvalid && s_tready && (s_tdata[2:0] != 3'b111 || 1'b1);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_NEXT(a_one_word_at_a_time, aclk, aresetn, in_word, !s_tready)
    `ASSERT_PROP(a_col_range, aclk, aresetn, m_tvalid |-> (32'(out_col) < 32'(COLUMNS)))
    `ASSERT_PROP(a_scroll_row, aclk, aresetn, (m_tvalid && out_scr) |-> ((out_row == ROW_LAST) || (out_row == ROW_PEND)))
    `ASSERT_PROP(a_scroll_no_read, aclk, aresetn, (m_tvalid && out_scr) |-> (m_tdata[27:12] == 16'd0))

endmodule

bind text_mode_console_writer_unit tmcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tmcw_checker (.*);

### verif/text_mode_console_writer_unit_tb.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit_tb
// Self-checking bench for the text-mode console writer. A clocked driver
// feeds command words from a backlog, and a shadow console predicts the
// cursor and read-back word for each one. A clocked monitor compares every
// result word field by field. Both sides insert random gaps, and the
// receiver holds off once for a long stretch. The text color is changed
// between phases, while the block is idle.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit_tb;
    import tmcw_pkg::*;

    localparam int COLS        = COLUMNS_DEF;
    localparam int ROWS        = ROWS_DEF;
    localparam int CELLS       = COLS * ROWS;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int SQUEEZE_LEN = 400;
    localparam int TAIL_CYCLES = 100;
    localparam int MAX_PRINTS  = 40;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic       pad;
        logic [4:0] row;
        logic [6:0] column;
        logic [7:0] character;
        logic [2:0] opcode;
    } console_cmd_t;

    typedef struct packed {
        logic [2:0] pad;
        logic       scrolled;
        logic [7:0] read_attribute;
        logic [7:0] read_character;
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
    } console_result_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [7:0]         cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [OUT_W-1:0]   m_tdata;

    // shadow console
    logic [15:0]        screen [CELLS];
    int unsigned        cursor_pos   = 0;
    logic [7:0]         shadow_color = TEXT_COLOR_INIT;

    console_cmd_t       cmd_backlog[$];
    console_result_t    expected_reports[$];

    int                 err_count   = 0;
    int                 cycle_count = 0;
    int                 feed_gap    = 0;
    int                 feed_calm   = 0;
    int                 drain_stall = 0;
    int                 drain_calm  = 0;
    int                 pick;
    int                 sink_pick;
    bit                 squeeze     = 1'b0;

    text_mode_console_writer_unit #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic console_result_t console_step(input console_cmd_t c);
        console_result_t r;
        int unsigned     slot;
        int              i;
        logic [7:0]      attr;
        r = '0;
        case (c.opcode)
            OP_PUT: begin
                if (cursor_pos >= CELLS) begin
                    for (i = 0; i < CELLS - COLS; i++)
                        screen[i] = screen[i + COLS];
                    for (i = CELLS - COLS; i < CELLS; i++)
                        screen[i] = {shadow_color, CH_SPACE};
                    cursor_pos -= COLS;
                    r.scrolled = 1'b1;
                end
                if (c.character == CH_NEWLINE) begin
                    cursor_pos += COLS;
                end else if (c.character == CH_RETURN) begin
                    cursor_pos -= cursor_pos % COLS;
                end else begin
                    screen[cursor_pos] = {shadow_color, c.character};
                    cursor_pos++;
                end
            end
            OP_BKSP: begin
                if (cursor_pos != 0) begin
                    cursor_pos--;
                    // cursor may still sit in the row past the bottom
                    if (cursor_pos < CELLS)
                        screen[cursor_pos] = {shadow_color, CH_SPACE};
                end
            end
            OP_INVERT: begin
                if (c.column < COLS && c.row < ROWS) begin
                    slot = c.row * COLS + c.column;
                    attr = screen[slot][15:8];
                    screen[slot][15:8] = {attr[3:0], attr[7:4]};
                end
            end
            OP_READ: begin
                if (c.column < COLS && c.row < ROWS) begin
                    slot = c.row * COLS + c.column;
                    r.read_character = screen[slot][7:0];
                    r.read_attribute = screen[slot][15:8];
                end
            end
            OP_CLEAR: begin
                shadow_color = TEXT_COLOR_INIT;
                for (i = 0; i < CELLS; i++)
                    screen[i] = {TEXT_COLOR_INIT, CH_SPACE};
                cursor_pos = 0;
            end
            default: ;
        endcase
        r.cursor_row    = 5'(cursor_pos / COLS);
        r.cursor_column = 7'(cursor_pos % COLS);
        return r;
    endfunction

    function automatic console_cmd_t console_cmd(input logic [2:0] op, input logic [7:0] ch,
                                                 input logic [6:0] col, input logic [4:0] row);
        console_cmd_t c;
        c = '0;
        c.opcode    = op;
        c.character = ch;
        c.column    = col;
        c.row       = row;
        return c;
    endfunction

    // mostly in-grid addresses, now and then anything the fields allow
    function automatic console_cmd_t random_cmd();
        int          p;
        logic [2:0]  op;
        logic [7:0]  ch;
        logic [6:0]  col;
        logic [4:0]  row;
        p   = $urandom_range(0, 99);
        ch  = 8'($urandom_range(0, 255));
        col = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, COLS - 1));
        row = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, ROWS - 1));
        if (p < 45) begin
            op = OP_PUT;
            if (p < 8)
                ch = CH_NEWLINE;
            else if (p < 11)
                ch = CH_RETURN;
        end else if (p < 60) begin
            op = OP_BKSP;
        end else if (p < 73) begin
            op = OP_INVERT;
        end else if (p < 93) begin
            op = OP_READ;
        end else if (p < 95) begin
            op = OP_CLEAR;
        end else begin
            op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        end
        return console_cmd(op, ch, col, row);
    endfunction

    // line-feed heavy runs push the cursor to the bottom and into scrolls
    task automatic queue_random(input int n);
        int          i;
        int          run;
        int          p;
        logic [7:0]  ch;
        run = 0;
        @(negedge aclk);
        for (i = 0; i < n; i++) begin
            if (run == 0 && $urandom_range(0, 24) == 0)
                run = $urandom_range(6, 28);
            if (run > 0) begin
                run--;
                p  = $urandom_range(0, 9);
                ch = (p < 8) ? CH_NEWLINE : (p == 8) ? CH_RETURN : 8'($urandom_range(0, 255));
                cmd_backlog.push_back(console_cmd(OP_PUT, ch, 7'($urandom_range(0, 127)),
                                                  5'($urandom_range(0, 31))));
            end else begin
                cmd_backlog.push_back(random_cmd());
            end
        end
    endtask

    task automatic write_color(input logic [7:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        shadow_color = v;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_tvalid || expected_reports.size() != 0);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
        if (err_count < MAX_PRINTS)
            $display("%0t: %s: got %0h, want %0h", $time, what, got_v, want_v);
        err_count++;
    endtask

    task automatic check_report(input console_result_t got);
        console_result_t want;
        if (expected_reports.size() == 0) begin
            flag_mismatch("result word with nothing outstanding", got, '0);
            return;
        end
        want = expected_reports.pop_front();
        if (got.cursor_row !== want.cursor_row)
            flag_mismatch("cursor_row", 32'(got.cursor_row), 32'(want.cursor_row));
        if (got.cursor_column !== want.cursor_column)
            flag_mismatch("cursor_column", 32'(got.cursor_column), 32'(want.cursor_column));
        if (got.read_character !== want.read_character)
            flag_mismatch("read_character", 32'(got.read_character),
                          32'(want.read_character));
        if (got.read_attribute !== want.read_attribute)
            flag_mismatch("read_attribute", 32'(got.read_attribute),
                          32'(want.read_attribute));
        if (got.scrolled !== want.scrolled)
            flag_mismatch("scrolled", 32'(got.scrolled), 32'(want.scrolled));
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            feed_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_reports.push_back(console_step(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    s_tdata  <= cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    if (feed_calm > 0) begin
                        feed_calm--;
                    end else begin
                        pick = $urandom_range(0, 99);
                        if (pick < 5)
                            feed_calm = $urandom_range(20, 60);
                        feed_gap = (pick < 55) ? 0 :
                                   (pick < 93) ? $urandom_range(1, 3) : $urandom_range(15, 60);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            drain_stall = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_report(m_tdata);
            if (drain_stall > 0) begin
                drain_stall--;
                m_tready <= 1'b0;
            end else if (squeeze) begin
                squeeze = 1'b0;
                drain_stall = SQUEEZE_LEN;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                if (drain_calm > 0) begin
                    drain_calm--;
                    sink_pick = 0;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                        drain_calm = $urandom_range(20, 60);
                    sink_pick = (pick < 55) ? 0 :
                                (pick < 93) ? $urandom_range(1, 3) : $urandom_range(15, 60);
                end
                drain_stall = (sink_pick > 0) ? sink_pick - 1 : 0;
                m_tready <= (sink_pick == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        write_color(8'h5a);

        // the cell RAM has no reset value: clear before anything reads it
        @(negedge aclk);
        cmd_backlog.push_back(console_cmd(OP_CLEAR, 8'h00, 7'd0, 5'd0));
        wait_drained();

        write_color(8'hff);
        @(negedge aclk);
        cmd_backlog.push_back(console_cmd(OP_BKSP, 8'h00, 7'd0, 5'd0));  // at origin
        cmd_backlog.push_back(console_cmd(OP_PUT, 8'h00, 7'd0, 5'd0));
        cmd_backlog.push_back(console_cmd(OP_PUT, 8'hff, 7'd127, 5'd31));
        cmd_backlog.push_back(console_cmd(OP_PUT, 8'h41, 7'd0, 5'd0));
        cmd_backlog.push_back(console_cmd(OP_PUT, CH_RETURN, 7'd0, 5'd0));
        cmd_backlog.push_back(console_cmd(OP_PUT, CH_NEWLINE, 7'd0, 5'd0));
        cmd_backlog.push_back(console_cmd(OP_BKSP, 8'hff, 7'd127, 5'd31)); // back to row 0
        cmd_backlog.push_back(console_cmd(OP_INVERT, 8'h00, 7'd0, 5'd0));
        cmd_backlog.push_back(console_cmd(OP_INVERT, 8'h00, 7'(COLS - 1), 5'(ROWS - 1)));
        cmd_backlog.push_back(console_cmd(OP_INVERT, 8'h00, 7'd127, 5'd31));
        cmd_backlog.push_back(console_cmd(OP_READ, 8'h00, 7'd0, 5'd0));
        cmd_backlog.push_back(console_cmd(OP_READ, 8'h00, 7'(COLS - 1), 5'd0));
        cmd_backlog.push_back(console_cmd(OP_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 1)));
        cmd_backlog.push_back(console_cmd(OP_READ, 8'h00, 7'(COLS), 5'd0));
        cmd_backlog.push_back(console_cmd(OP_READ, 8'h00, 7'd0, 5'(ROWS)));
        cmd_backlog.push_back(console_cmd(OP_READ, 8'hff, 7'd127, 5'd31));
        cmd_backlog.push_back(console_cmd(OP_UNUSED_FIRST, 8'h00, 7'd0, 5'd0));
        cmd_backlog.push_back(console_cmd(OP_UNUSED_FIRST + 3'd1, 8'h55, 7'd42, 5'd10));
        cmd_backlog.push_back(console_cmd(OP_UNUSED_LAST, 8'hff, 7'd127, 5'd31));
        cmd_backlog.push_back(console_cmd(OP_CLEAR, 8'hff, 7'd127, 5'd31));
        cmd_backlog.push_back(console_cmd(OP_READ, 8'h00, 7'd5, 5'd5));
        wait_drained();

        write_color(8'h00);
        queue_random(150);
        wait_drained();

        write_color(8'($urandom_range(1, 254)));
        @(negedge aclk);
        squeeze = 1'b1;   // receiver holds off while the backlog keeps coming
        queue_random(150);
        wait_drained();

        write_color(8'($urandom_range(0, 255)));
        queue_random(150);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
